// File: rtl/core/tsg_pkg.sv
// Shared types and constants of the three-tone noise sound generator.
// Used by scoped names in rtl/core (all but tsg_if) and the testbench.
package tsg_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_STEP = 2'd0;
    localparam logic [1:0] CFG_GAIN = 2'd1;
    localparam logic [1:0] CFG_AMP  = 2'd2;

    // tone registers of the noise mode and of the channel 2 period
    localparam logic [2:0] TR_NOISE  = 3'd6;
    localparam logic [2:0] TR_PERIOD2 = 3'd4;

    localparam logic [19:0] STEP_RESET = 20'd12917;
    localparam logic [5:0]  GAIN_RESET = 6'd0;
    localparam logic [15:0] AMP_RESET  = 16'd16384;

    localparam logic [16:0] STEP_ONE     = 17'h10000;
    localparam logic [21:0] FULL_LEVEL   = 22'd2796117;
    localparam logic [16:0] GAIN_MUL     = 17'd67063;
    localparam logic [16:0] ATTN_MUL     = 17'd52057;
    localparam logic [16:0] NOISE_SEED   = 17'h00f35;
    localparam logic [16:0] TAP_WHITE    = 17'h14002;
    localparam logic [16:0] TAP_PERIODIC = 17'h08000;
    localparam logic signed [48:0] MIX_LIMIT = 49'sh7fff000000;

    typedef struct packed {
        logic [19:0] step;
        logic [5:0]  gain;
        logic [15:0] amp;
    } cfg_t;

    typedef struct packed {
        logic signed [25:0] a;
        logic signed [22:0] b;
    } mul_req_t;

    typedef struct packed {
        logic take;
        logic rebuild;
        logic space;
    } seq_ctl_t;

    typedef struct packed {
        logic idle;
        logic emit;
    } seq_sts_t;

endpackage

// File: rtl/core/tsg_if.sv
// Channel interfaces of the sound generator: input words, result words
// and configuration writes. No dependencies.
interface tsg_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data;
    modport source (output valid, output func, output data, input ready);
    modport sink (input valid, input func, input data, output ready);
endinterface

interface tsg_result_if;
    logic        valid;
    logic        ready;
    logic [16:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface tsg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/tsg_mul.sv
// Shared signed multiplier with a registered product.
// Depends on tsg_pkg.
module tsg_mul (
    input  logic                clk,
    input  tsg_pkg::mul_req_t   req,
    output logic signed [48:0]  prod
);

    logic signed [48:0] prod_reg;
    logic signed [48:0] prod_next;

    assign prod_next = 49'(req.a) * 49'(req.b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/core/tsg_seq.sv
// Sequencer and datapath: level table build, register writes, tone and
// noise stepping, mixing and scaling. Depends on tsg_pkg and tsg_mul.
module tsg_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsg_pkg::cfg_t        cfg,
    input  tsg_pkg::seq_ctl_t    ctl,
    input  logic                 func,
    input  logic [7:0]           data,
    output tsg_pkg::seq_sts_t    sts,
    output logic [16:0]          sample
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BINIT  = 4'd1;
    localparam logic [3:0] S_BGAIN  = 4'd2;
    localparam logic [3:0] S_BGAINW = 4'd3;
    localparam logic [3:0] S_BATT   = 4'd4;
    localparam logic [3:0] S_BATTW  = 4'd5;
    localparam logic [3:0] S_WR     = 4'd6;
    localparam logic [3:0] S_WRP    = 4'd7;
    localparam logic [3:0] S_SIL    = 4'd8;
    localparam logic [3:0] S_TSTART = 4'd9;
    localparam logic [3:0] S_TLOOP  = 4'd10;
    localparam logic [3:0] S_TEND   = 4'd11;
    localparam logic [3:0] S_NLOOP  = 4'd12;
    localparam logic [3:0] S_MIX    = 4'd13;
    localparam logic [3:0] S_AMP    = 4'd14;
    localparam logic [3:0] S_OUT    = 4'd15;

    tsg_pkg::mul_req_t  mreq;
    logic signed [48:0] prod;

    tsg_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    logic [3:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [3:0]  k_reg, k_next;
    logic [1:0]  ch_reg, ch_next;
    logic [23:0] g_reg, g_next;
    logic [21:0] rom_reg [16];
    logic [21:0] rom_next [16];
    logic [21:0] lvl_reg [4];
    logic [21:0] lvl_next [4];
    logic [9:0]  tr_reg [8];
    logic [9:0]  tr_next [8];
    logic [2:0]  latch_reg, latch_next;
    logic [2:0]  sel_reg, sel_next;
    logic [7:0]  data_reg, data_next;
    logic [31:0] half_reg [4];
    logic [31:0] half_next [4];
    logic signed [33:0] phase_reg [4];
    logic signed [33:0] phase_next [4];
    logic [3:0]  wave_reg, wave_next;
    logic [16:0] lfsr_reg, lfsr_next;
    logic        white_reg, white_next;
    logic signed [35:0] vacc_reg, vacc_next;
    logic signed [17:0] vol_reg [4];
    logic signed [17:0] vol_next [4];
    logic [16:0] left_reg, left_next;
    logic signed [48:0] macc_reg, macc_next;
    logic [38:0] mixc_reg, mixc_next;
    logic [55:0] aacc_reg, aacc_next;
    logic [16:0] sample_reg, sample_next;

    logic [19:0] step_eff;
    assign step_eff = (cfg.step == 20'd0) ? 20'd1 : cfg.step;

    always_comb
    begin
        logic [2:0]  wsel;
        logic [9:0]  wval;
        logic [31:0] hp;
        logic signed [33:0] tp;
        logic signed [33:0] tper;
        logic signed [33:0] tp1;
        logic signed [35:0] tv;
        logic signed [33:0] np;
        logic signed [33:0] nleft;
        logic signed [33:0] nev;
        logic signed [33:0] nph;
        logic signed [35:0] nv;
        logic [16:0] nl;
        logic        nw;
        logic [16:0] nrem;
        logic signed [48:0] msum;
        logic [55:0] atot;

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        ch_next     = ch_reg;
        g_next      = g_reg;
        rom_next    = rom_reg;
        lvl_next    = lvl_reg;
        tr_next     = tr_reg;
        latch_next  = latch_reg;
        sel_next    = sel_reg;
        data_next   = data_reg;
        half_next   = half_reg;
        phase_next  = phase_reg;
        wave_next   = wave_reg;
        lfsr_next   = lfsr_reg;
        white_next  = white_reg;
        vacc_next   = vacc_reg;
        vol_next    = vol_reg;
        left_next   = left_reg;
        macc_next   = macc_reg;
        mixc_next   = mixc_reg;
        aacc_next   = aacc_reg;
        sample_next = sample_reg;
        mreq        = '0;

        wsel  = '0;
        wval  = '0;
        hp    = '0;
        tp    = phase_reg[ch_reg];
        tper  = $signed({2'b00, half_reg[ch_reg]});
        tp1   = tp + tper;
        tv    = vacc_reg;
        np    = phase_reg[3];
        nleft = $signed({17'b0, left_reg});
        nev   = '0;
        nph   = '0;
        nv    = '0;
        nl    = lfsr_reg;
        nw    = wave_reg[3];
        nrem  = '0;
        msum  = macc_reg + prod;
        atot  = aacc_reg + {20'b0, prod[35:0]};

        case (state_reg)
            S_IDLE:
            begin
                if (ctl.rebuild)
                begin
                    state_next = S_BINIT;
                end
                else if (ctl.take)
                begin
                    data_next  = data;
                    state_next = func ? S_SIL : S_WR;
                end
            end

            S_BINIT:
            begin
                g_next     = {2'b00, tsg_pkg::FULL_LEVEL};
                cnt_next   = cfg.gain;
                k_next     = '0;
                state_next = S_BGAIN;
            end

            S_BGAIN:
            begin
                if (cnt_reg != 6'd0)
                begin
                    mreq.a     = $signed({2'b00, g_reg});
                    mreq.b     = $signed({6'b0, tsg_pkg::GAIN_MUL});
                    state_next = S_BGAINW;
                end
                else
                begin
                    state_next = S_BATT;
                end
            end

            S_BGAINW:
            begin
                g_next     = 24'((prod + 49'sd32768) >>> 16);
                cnt_next   = cnt_reg - 6'd1;
                state_next = S_BGAIN;
            end

            S_BATT:
            begin
                rom_next[k_reg] = (g_reg > {2'b00, tsg_pkg::FULL_LEVEL}) ?
                                  tsg_pkg::FULL_LEVEL : g_reg[21:0];
                mreq.a = $signed({2'b00, g_reg});
                mreq.b = $signed({6'b0, tsg_pkg::ATTN_MUL});
                if (k_reg == 4'd14)
                begin
                    rom_next[15] = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_BATTW;
                end
            end

            S_BATTW:
            begin
                g_next     = 24'((prod + 49'sd32768) >>> 16);
                k_next     = k_reg + 4'd1;
                state_next = S_BATT;
            end

            S_WR:
            begin
                if (data_reg[7])
                begin
                    wsel       = data_reg[6:4];
                    latch_next = wsel;
                    wval       = {tr_reg[wsel][9:4], data_reg[3:0]};
                end
                else
                begin
                    wsel = latch_reg;
                    if (!wsel[0] && wsel != tsg_pkg::TR_NOISE)
                        wval = {data_reg[5:0], tr_reg[wsel][3:0]};
                    else
                        wval = {tr_reg[wsel][9:4], data_reg[3:0]};
                end
                tr_next[wsel] = wval;
                sel_next      = wsel;
                if (!wsel[0] && wsel != tsg_pkg::TR_NOISE)
                begin
                    mreq.a     = $signed({6'b0, step_eff});
                    mreq.b     = $signed({13'b0, wval});
                    state_next = S_WRP;
                end
                else if (wsel == tsg_pkg::TR_NOISE)
                begin
                    white_next = wval[2];
                    if (wval[1:0] == 2'b11)
                        half_next[3] = {half_reg[2][30:0], 1'b0};
                    else
                        half_next[3] = {12'b0, step_eff} << (3'd5 + {1'b0, wval[1:0]});
                    lfsr_next    = tsg_pkg::NOISE_SEED;
                    wave_next[3] = tsg_pkg::NOISE_SEED[0];
                    state_next   = S_IDLE;
                end
                else
                begin
                    lvl_next[wsel[2:1]] = rom_reg[data_reg[3:0]];
                    state_next          = S_IDLE;
                end
            end

            S_WRP:
            begin
                hp = (prod[29:0] == 30'd0) ? {12'b0, step_eff} : {2'b00, prod[29:0]};
                half_next[sel_reg[2:1]] = hp;
                if (sel_reg == tsg_pkg::TR_PERIOD2 &&
                    tr_reg[tsg_pkg::TR_NOISE][1:0] == 2'b11)
                    half_next[3] = {hp[30:0], 1'b0};
                state_next = S_IDLE;
            end

            S_SIL:
            begin
                // silent channels get one extra sample of count
                for (int i = 0; i < 4; i++)
                begin
                    if (lvl_reg[i] == 22'd0 &&
                        phase_reg[i] <= $signed({17'b0, tsg_pkg::STEP_ONE}))
                        phase_next[i] = phase_reg[i] + $signed({17'b0, tsg_pkg::STEP_ONE});
                end
                ch_next    = 2'd0;
                state_next = S_TSTART;
            end

            S_TSTART:
            begin
                vacc_next = wave_reg[ch_reg] ? 36'(tp) : 36'sd0;
                phase_next[ch_reg] = tp - $signed({17'b0, tsg_pkg::STEP_ONE});
                state_next = S_TLOOP;
            end

            S_TLOOP:
            begin
                // one full period per cycle until the count turns positive
                if (tp <= 34'sd0)
                begin
                    if (tp1 > 34'sd0)
                    begin
                        wave_next[ch_reg]  = !wave_reg[ch_reg];
                        phase_next[ch_reg] = tp1;
                        if (!wave_reg[ch_reg])
                            vacc_next = vacc_reg + 36'(tper);
                        state_next = S_TEND;
                    end
                    else
                    begin
                        phase_next[ch_reg] = tp1 + tper;
                        vacc_next          = vacc_reg + 36'(tper);
                    end
                end
                else
                begin
                    state_next = S_TEND;
                end
            end

            S_TEND:
            begin
                if (wave_reg[ch_reg])
                    tv = vacc_reg - 36'(tp);
                vol_next[ch_reg] = tv[17:0];
                if (ch_reg == 2'd2)
                begin
                    vacc_next  = '0;
                    left_next  = tsg_pkg::STEP_ONE;
                    state_next = S_NLOOP;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_TSTART;
                end
            end

            S_NLOOP:
            begin
                nev = (np < nleft) ? np : nleft;
                if (nev < 34'sd0)
                    nev = '0;
                nv  = vacc_reg + (wave_reg[3] ? 36'(np) : 36'sd0);
                nph = np - nev;
                if (nph <= 34'sd0)
                begin
                    if (nl[0])
                        nl = nl ^ (white_reg ? tsg_pkg::TAP_WHITE : tsg_pkg::TAP_PERIODIC);
                    nl  = nl >> 1;
                    nw  = nl[0];
                    nph = nph + $signed({2'b00, half_reg[3]});
                    if (nw)
                        nv = nv + $signed({4'b0, half_reg[3]});
                end
                if (nw)
                    nv = nv - 36'(nph);
                nrem          = left_reg - nev[16:0];
                lfsr_next     = nl;
                wave_next[3]  = nw;
                phase_next[3] = nph;
                vacc_next     = nv;
                left_next     = nrem;
                if (nrem == 17'd0)
                begin
                    vol_next[3] = nv[17:0];
                    k_next      = '0;
                    state_next  = S_MIX;
                end
            end

            S_MIX:
            begin
                if (k_reg < 4'd4)
                begin
                    mreq.a = $signed({4'b0, lvl_reg[k_reg[1:0]]});
                    mreq.b = 23'(vol_reg[k_reg[1:0]]);
                end
                macc_next = (k_reg == 4'd0) ? 49'sd0 : msum;
                if (k_reg == 4'd4)
                begin
                    if (msum < 49'sd0)
                        mixc_next = '0;
                    else if (msum > tsg_pkg::MIX_LIMIT)
                        mixc_next = tsg_pkg::MIX_LIMIT[38:0];
                    else
                        mixc_next = msum[38:0];
                    k_next     = '0;
                    state_next = S_AMP;
                end
                else
                begin
                    k_next = k_reg + 4'd1;
                end
            end

            S_AMP:
            begin
                mreq.b = $signed({7'b0, cfg.amp});
                if (k_reg == 4'd0)
                begin
                    mreq.a = $signed({7'b0, mixc_reg[38:20]});
                    k_next = 4'd1;
                end
                else if (k_reg == 4'd1)
                begin
                    mreq.a    = $signed({6'b0, mixc_reg[19:0]});
                    aacc_next = {prod[35:0], 20'b0};
                    k_next    = 4'd2;
                end
                else
                begin
                    sample_next = atot[54:38];
                    state_next  = S_OUT;
                end
            end

            S_OUT:
            begin
                if (ctl.space)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BINIT;
            latch_reg <= '0;
            lfsr_reg  <= tsg_pkg::NOISE_SEED;
            white_reg <= 1'b0;
            wave_reg  <= {tsg_pkg::NOISE_SEED[0], 3'b000};
            for (int i = 0; i < 4; i++)
            begin
                lvl_reg[i]       <= '0;
                half_reg[i]      <= {12'b0, tsg_pkg::STEP_RESET};
                phase_reg[i]     <= $signed({14'b0, tsg_pkg::STEP_RESET});
                tr_reg[2 * i]     <= 10'd0;
                tr_reg[2 * i + 1] <= 10'd15;
            end
        end
        else
        begin
            state_reg <= state_next;
            latch_reg <= latch_next;
            lfsr_reg  <= lfsr_next;
            white_reg <= white_next;
            wave_reg  <= wave_next;
            lvl_reg   <= lvl_next;
            half_reg  <= half_next;
            phase_reg <= phase_next;
            tr_reg    <= tr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
        ch_reg     <= ch_next;
        g_reg      <= g_next;
        rom_reg    <= rom_next;
        sel_reg    <= sel_next;
        data_reg   <= data_next;
        vacc_reg   <= vacc_next;
        vol_reg    <= vol_next;
        left_reg   <= left_next;
        macc_reg   <= macc_next;
        mixc_reg   <= mixc_next;
        aacc_reg   <= aacc_next;
        sample_reg <= sample_next;
    end

    assign sts.idle = (state_reg == S_IDLE);
    assign sts.emit = (state_reg == S_OUT) && ctl.space;
    assign sample   = sample_reg;

endmodule

// File: rtl/core/three_tone_noise_sound_generator_unit.sv
// Top level of the three-tone noise sound generator: configuration
// registers, result register and the sequencer. Depends on tsg_pkg,
// tsg_if and tsg_seq.
//
//   channel  role    payload               word
//   item     sink    func[0], data[7:0]    one register byte or one tick
//   result   source  sample[16:0]          one mixed sample per tick
//   cfg      sink    index[1:0], data[19:0] one register write
//
// A register byte runs S_WR, and S_WRP after it for a period byte. A tick
// runs S_SIL, per tone channel S_TSTART, S_TLOOP passes that each skip two
// half periods and S_TEND, S_NLOOP passes over the noise events, S_MIX,
// S_AMP and S_OUT; short periods lengthen it. The level table is rebuilt
// after reset and each gain write; item and cfg are not ready meanwhile.
// A finished sample waits in the result register; the next item is taken
// while it waits, and a later tick holds until the register frees up.
module three_tone_noise_sound_generator_unit (
    input  logic         clk,
    input  logic         rst_n,
    tsg_item_if.sink     item,
    tsg_result_if.source result,
    tsg_cfg_if.sink      cfg
);

    logic [19:0] step_reg;
    logic [5:0]  gain_reg;
    logic [15:0] amp_reg;
    logic        res_valid_reg, res_valid_next;
    logic [16:0] res_sample_reg;

    tsg_pkg::cfg_t     cfg_val;
    tsg_pkg::seq_ctl_t ctl;
    tsg_pkg::seq_sts_t sts;
    logic [16:0]       seq_sample;
    logic              cfg_take;

    assign cfg.ready  = sts.idle;
    assign item.ready = sts.idle && !cfg.valid;
    assign cfg_take   = cfg.valid && sts.idle;

    assign cfg_val.step = step_reg;
    assign cfg_val.gain = gain_reg;
    assign cfg_val.amp  = amp_reg;

    assign ctl.take    = item.valid && item.ready;
    assign ctl.rebuild = cfg_take && (cfg.index == tsg_pkg::CFG_GAIN);
    assign ctl.space   = !res_valid_reg || result.ready;

    tsg_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_val),
        .ctl    (ctl),
        .func   (item.func),
        .data   (item.data),
        .sts    (sts),
        .sample (seq_sample)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= tsg_pkg::STEP_RESET;
            gain_reg <= tsg_pkg::GAIN_RESET;
            amp_reg  <= tsg_pkg::AMP_RESET;
        end
        else if (cfg_take)
        begin
            case (cfg.index)
                tsg_pkg::CFG_STEP: step_reg <= cfg.data;
                tsg_pkg::CFG_GAIN: gain_reg <= cfg.data[5:0];
                tsg_pkg::CFG_AMP:  amp_reg  <= cfg.data[15:0];
                default:           ;
            endcase
        end
    end

    // hold the sample until taken; load a new one over a word being taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (sts.emit)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (sts.emit)
            res_sample_reg <= seq_sample;
    end

    assign result.valid  = res_valid_reg;
    assign result.sample = res_sample_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of three_tone_noise_sound_generator_unit: register
// bytes and ticks in, mixed samples out, checked against an in-bench model.
// Depends on tsg_pkg, tsg_if and three_tone_noise_sound_generator_unit.
module testbench;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;
    localparam longint ONE_STEP = 64'h10000;
    localparam longint FULL_LVL = 2796117;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 24;

    typedef struct {
        logic       func;
        logic [7:0] data;
    } word_t;

    logic clk;
    logic rst_n;

    tsg_item_if   item ();
    tsg_result_if result ();
    tsg_cfg_if    cfg ();

    three_tone_noise_sound_generator_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // sound model state
    logic [19:0]     m_step;
    logic [5:0]      m_gain;
    logic [15:0]     m_amp;
    logic [9:0]      m_tone [8];
    logic [2:0]      m_latch;
    longint          m_half [4];
    longint          m_phase [4];
    logic            m_wave [4];
    logic [16:0]     m_lfsr;
    logic            m_white;
    longint unsigned m_chan_lvl [4];
    longint unsigned m_lvl_table [16];

    word_t       pending_words [$];
    logic [16:0] expected_samples [$];
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 4;
    int          gap_left = 0;
    int          stall_mode = 0;
    logic        hold_off;
    logic        hold_go = 1'b0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic report(input string what, input logic [16:0] got, input logic [16:0] want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint step_eff();
        return (m_step == 0) ? 64'd1 : longint'(m_step);
    endfunction

    function automatic void rebuild_level_table();
        longint unsigned g;
        g = FULL_LVL;
        for (int k = 0; k < m_gain; k++)
            g = (g * 67063 + 32768) >> 16;
        for (int k = 0; k < 15; k++)
        begin
            m_lvl_table[k] = (g > FULL_LVL) ? FULL_LVL : g;
            g = (g * 52057 + 32768) >> 16;
        end
        m_lvl_table[15] = 0;
    endfunction

    function automatic void reseed_noise();
        m_lfsr = tsg_pkg::NOISE_SEED;
        m_wave[3] = m_lfsr[0];
    endfunction

    function automatic void model_reset();
        m_step = tsg_pkg::STEP_RESET;
        m_gain = tsg_pkg::GAIN_RESET;
        m_amp = tsg_pkg::AMP_RESET;
        rebuild_level_table();
        for (int i = 0; i < 4; i++)
        begin
            m_tone[i*2] = '0;
            m_tone[i*2+1] = 10'h00f;
            m_chan_lvl[i] = 0;
            m_wave[i] = 1'b0;
            m_half[i] = step_eff();
            m_phase[i] = step_eff();
        end
        m_latch = '0;
        reseed_noise();
        m_white = 1'b0;
    endfunction

    function automatic void sound_write_byte(input logic [7:0] d);
        logic [2:0] r;
        logic [1:0] mode;
        if (d[7])
        begin
            r = d[6:4];
            m_latch = r;
            m_tone[r] = {m_tone[r][9:4], d[3:0]};
        end
        else
        begin
            r = m_latch;
            if (r == 0 || r == 2 || r == 4)
                m_tone[r] = {d[5:0], m_tone[r][3:0]};
            else
                m_tone[r] = {m_tone[r][9:4], d[3:0]};
        end
        if (r == 0 || r == 2 || r == 4)
        begin
            m_half[r[2:1]] = step_eff() * longint'(m_tone[r]);
            if (m_half[r[2:1]] == 0)
                m_half[r[2:1]] = step_eff();
            if (r == tsg_pkg::TR_PERIOD2 && m_tone[tsg_pkg::TR_NOISE][1:0] == 2'd3)
                m_half[3] = m_half[2] * 2;
        end
        else if (r == tsg_pkg::TR_NOISE)
        begin
            m_white = m_tone[tsg_pkg::TR_NOISE][2];
            mode = m_tone[tsg_pkg::TR_NOISE][1:0];
            m_half[3] = (mode == 2'd3) ? m_half[2] * 2 : step_eff() << (5 + mode);
            reseed_noise();
        end
        else
            m_chan_lvl[r[2:1]] = m_lvl_table[d[3:0]];
    endfunction

    function automatic logic [16:0] sound_tick();
        longint vol [4];
        longint left;
        longint mix;
        longint per;
        longint ev;
        longint unsigned scaled;
        left = ONE_STEP;
        mix = 0;
        for (int i = 0; i < 4; i++)
        begin
            vol[i] = 0;
            if (m_chan_lvl[i] == 0 && m_phase[i] <= ONE_STEP)
                m_phase[i] += ONE_STEP;
        end
        for (int i = 0; i < 3; i++)
        begin
            per = m_half[i];
            if (m_wave[i]) vol[i] += m_phase[i];
            m_phase[i] -= ONE_STEP;
            while (m_phase[i] <= 0)
            begin
                m_phase[i] += per;
                if (m_phase[i] > 0)
                begin
                    m_wave[i] = ~m_wave[i];
                    if (m_wave[i]) vol[i] += per;
                    break;
                end
                m_phase[i] += per;
                vol[i] += per;
            end
            if (m_wave[i]) vol[i] -= m_phase[i];
        end
        do
        begin
            ev = (m_phase[3] < left) ? m_phase[3] : left;
            if (ev < 0) ev = 0;
            if (m_wave[3]) vol[3] += m_phase[3];
            m_phase[3] -= ev;
            if (m_phase[3] <= 0)
            begin
                if (m_lfsr[0]) m_lfsr ^= m_white ? tsg_pkg::TAP_WHITE : tsg_pkg::TAP_PERIODIC;
                m_lfsr = m_lfsr >> 1;
                m_wave[3] = m_lfsr[0];
                m_phase[3] += m_half[3];
                if (m_wave[3]) vol[3] += m_half[3];
            end
            if (m_wave[3]) vol[3] -= m_phase[3];
            left -= ev;
        end
        while (left > 0);
        for (int i = 0; i < 4; i++)
            mix += vol[i] * longint'(m_chan_lvl[i]);
        if (mix > longint'(tsg_pkg::MIX_LIMIT)) mix = longint'(tsg_pkg::MIX_LIMIT);
        if (mix < 0) mix = 0;
        scaled = longint'(mix) * longint'(m_amp);
        return scaled[54:38];
    endfunction

    // driver: bursts of words with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item.valid <= 1'b0;
            item.func <= 1'b0;
            item.data <= '0;
        end
        else
        begin : drive
            logic offer;
            word_t w;
            offer = 1'b0;
            if (item.valid && item.ready)
            begin
                w = pending_words.pop_front();
                if (w.func == FUNC_TICK)
                    expected_samples.push_back(sound_tick());
                else
                    sound_write_byte(w.data);
            end
            if (item.valid && !item.ready)
                offer = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (pending_words.size() > 0)
            begin
                offer = 1'b1;
                item.func <= pending_words[0].func;
                item.data <= pending_words[0].data;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            item.valid <= offer;
        end
    end

    // receiver stall pattern, switched now and then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode = $urandom_range(0, 2);
            if (hold_off)
                result.ready <= 1'b0;
            else if (stall_mode == 0)
                result.ready <= 1'b1;
            else if (stall_mode == 1)
                result.ready <= ($urandom_range(0, 3) != 0);
            else
                result.ready <= ($urandom_range(0, 2) == 0);
        end
    end

    // long hold-off on the result side while words keep coming
    initial
    begin
        hold_off <= 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (800) @(posedge clk);
        hold_off <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_samples.size() == 0)
                report("unexpected sample", result.sample, '0);
            else if (result.sample !== expected_samples[0])
                report("sample", result.sample, expected_samples.pop_front());
            else
                void'(expected_samples.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("three_tone_noise_sound_generator_unit verification failed");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] d);
        word_t w;
        w.func = FUNC_WRITE;
        w.data = d;
        pending_words.push_back(w);
    endtask

    task automatic push_tick();
        word_t w;
        w.func = FUNC_TICK;
        w.data = 8'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && expected_samples.size() == 0 && !item.valid);
        repeat (SETTLE) @(posedge clk);
    endtask

    // drop valid at the accepting edge, idle to the next edge, then return
    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        if (idx == tsg_pkg::CFG_STEP)
            m_step = val;
        else if (idx == tsg_pkg::CFG_GAIN)
        begin
            m_gain = val[5:0];
            rebuild_level_table();
        end
        else
            m_amp = val[15:0];
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_period(input int ch, input logic [9:0] p);
        push_byte({1'b1, 3'(ch * 2), p[3:0]});
        push_byte({2'b00, p[9:4]});
    endtask

    // rewrite every period, volume and noise mode so the rates follow the step
    task automatic retune(input logic [9:0] lo_limit);
        for (int c = 0; c < 3; c++)
        begin
            set_period(c, 10'($urandom_range(lo_limit, 1023)));
            push_byte({1'b1, 3'(c * 2 + 1), 4'($urandom)});
        end
        push_byte({5'b11100, 3'($urandom)});
        push_byte({4'b1111, 4'($urandom)});
    endtask

    task automatic new_settings(input logic [19:0] s, input logic [5:0] g, input logic [15:0] a);
        write_reg(tsg_pkg::CFG_STEP, s);
        write_reg(tsg_pkg::CFG_GAIN, {14'd0, g});
        write_reg(tsg_pkg::CFG_AMP, {4'd0, a});
    endtask

    initial
    begin
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        model_reset();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: silent start, zero and max period, three noise modes
        push_tick();
        push_byte(8'h80);
        push_byte(8'h00);
        push_byte(8'h90);
        push_byte(8'hA5);
        push_byte(8'h3F);
        push_byte(8'hB0);
        push_byte(8'hCF);
        push_byte(8'h3F);
        push_byte(8'hD7);
        push_byte(8'hE7);
        push_byte(8'hF0);
        push_tick();
        push_tick();
        push_byte(8'hC1);
        push_byte(8'h15);
        push_tick();
        push_byte(8'hE4);
        push_tick();
        push_byte(8'hE2);
        push_tick();
        push_byte(8'h0F);
        push_tick();
        push_byte(8'hFF);
        push_tick();
        drain();

        // zero step, full gain and amplitude; long periods keep ticks short
        new_settings(20'd0, 6'd63, 16'hFFFF);
        for (int c = 0; c < 3; c++)
        begin
            set_period(c, 10'd1023);
            push_byte({1'b1, 3'(c * 2 + 1), 4'd0});
        end
        push_byte(8'hE7);
        push_byte(8'hF0);
        repeat (4) push_tick();
        drain();

        new_settings(20'hFFFFF, 6'd0, 16'd0);
        retune(10'd0);
        repeat (6) push_tick();
        drain();

        for (int ph = 0; ph < 11; ph++)
        begin
            new_settings(20'($urandom_range(4096, 1048575)), 6'($urandom), 16'($urandom));
            retune(10'd0);
            for (int n = 0; n < 150; n++)
            begin
                if ($urandom_range(0, 99) < 45)
                    push_tick();
                else
                    push_byte(8'($urandom));
            end
            if (ph == 3)
                hold_go = 1'b1;
            drain();
        end

        if (errors == 0)
            $display("three_tone_noise_sound_generator_unit verification clean");
        else
            $display("three_tone_noise_sound_generator_unit verification failed");
        $finish;
    end

endmodule
